### rtl/keyframe_linear_interpolator_top_macros.svh
// ----------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe interpolator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe interpolator assertion failed");

`endif

### rtl/kli_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Shared widths, codes and the command and status bundles.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned IDX_IN_W     = 6;
  localparam int unsigned CNT_IN_W     = 7;
  localparam int unsigned S_TDATA_W    = 168;
  localparam int unsigned M_TDATA_W    = 96;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BEFORE = 2'd1,
    STATUS_AFTER  = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } key_t;

  typedef struct packed {
    logic    key_wr;
    logic    q_load;
    logic    idx_clr;
    logic    idx_inc;
    logic    prev_load;
    logic    nxt_load;
    logic    res_empty;
    logic    res_key;
    status_e res_status;
    logic    div_start;
    logic    mul_step;
    logic    acc_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic q_lt_cur;
    logic q_eq_cur;
    logic cur_last;
    logic div_busy;
    logic axis_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/kli_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Radix-2 restoring divider that yields one fraction bit per cycle.
// ----------------------------------------------------------------------------
module kli_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kli_pkg::TIME_W-1:0]    num_i,
  input  logic [kli_pkg::TIME_W-1:0]    den_i,
  output logic                          busy_o,
  output logic [kli_pkg::FRAC_W-1:0]    quo_o
);

  localparam int unsigned CNT_W = $clog2(kli_pkg::FRAC_W + 1);

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [kli_pkg::TIME_W-1:0]   rem_q, rem_d;
  logic [kli_pkg::TIME_W-1:0]   den_q;
  logic [kli_pkg::FRAC_W-1:0]   quo_q, quo_d;
  logic [kli_pkg::TIME_W:0]     rem2;
  logic                         ge;

  // The remainder always stays below the divisor, so the shifted value fits
  // one extra bit.
  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = CNT_W'(kli_pkg::FRAC_W);
      rem_d = num_i;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = ge ? kli_pkg::TIME_W'(rem2 - {1'b0, den_q}) : rem2[kli_pkg::TIME_W-1:0];
      quo_d = {quo_q[kli_pkg::FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

### rtl/kli_dp.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Key memory, scan registers, divider, shared multiplier and result stage.
// ----------------------------------------------------------------------------
module kli_dp #(
  parameter int unsigned MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kli_pkg::CNT_IN_W-1:0]    cfg_wdata_i,
  input  logic [kli_pkg::IDX_IN_W-1:0]    key_index_i,
  input  logic [kli_pkg::TIME_W-1:0]      key_time_i,
  input  logic [kli_pkg::VAL_W-1:0]       key_x_i,
  input  logic [kli_pkg::VAL_W-1:0]       key_y_i,
  input  logic [kli_pkg::VAL_W-1:0]       key_z_i,
  input  logic [kli_pkg::TIME_W-1:0]      query_time_i,
  input  kli_pkg::cmd_t                   cmd_i,
  output kli_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [kli_pkg::VAL_W-1:0]       out_x_o,
  output logic [kli_pkg::VAL_W-1:0]       out_y_o,
  output logic [kli_pkg::VAL_W-1:0]       out_z_o,
  output kli_pkg::status_e                out_status_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int unsigned PROD_W = kli_pkg::VAL_W + kli_pkg::FRAC_W + 2;
  localparam int unsigned SUM_W  = kli_pkg::VAL_W + 2;

  kli_pkg::key_t                  mem_q [MAX_KEYS];
  kli_pkg::key_t                  rd_q, prev_q, nxt_q, wr_key;
  logic [IDX_W-1:0]               wr_addr, rd_addr;
  logic                           wr_en;
  logic [kli_pkg::CNT_IN_W-1:0]   key_count_q;
  logic [CNT_W-1:0]               n, idx_q, cur_q;
  logic [kli_pkg::TIME_W-1:0]     q_q;
  kli_pkg::axis_e                 axis_q;
  logic                           div_busy;
  logic [kli_pkg::FRAC_W-1:0]     frac;
  logic [kli_pkg::VAL_W-1:0]      a, b;
  logic signed [kli_pkg::VAL_W:0] diff;
  logic signed [PROD_W-1:0]       prod_q;
  logic [SUM_W-1:0]               sum;
  logic [kli_pkg::VAL_W-1:0]      res_x_q, res_y_q, res_z_q;
  kli_pkg::status_e               res_status_q;
  logic                           out_valid_q;
  logic [kli_pkg::VAL_W-1:0]      out_x_q, out_y_q, out_z_q;
  kli_pkg::status_e               out_status_q;

  // Key count register; the usable count saturates at the table depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  assign n = (32'(key_count_q) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_q);

  // Key memory: one write port for loads, one registered read port for the scan.
  assign wr_en   = cmd_i.key_wr && (32'(key_index_i) < MAX_KEYS);
  assign wr_addr = IDX_W'(key_index_i);
  assign wr_key  = '{t: key_time_i, x: key_x_i, y: key_y_i, z: key_z_i};
  assign rd_addr = (32'(idx_q) < MAX_KEYS) ? IDX_W'(idx_q) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_key;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Scan registers. cur_q names the entry that rd_q holds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    cur_q <= idx_q;
    if (cmd_i.q_load) begin
      q_q <= query_time_i;
    end
    if (cmd_i.prev_load) begin
      prev_q <= rd_q;
    end
    if (cmd_i.nxt_load) begin
      nxt_q <= rd_q;
    end
  end

  kli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (q_q - prev_q.t),
    .den_i   (rd_q.t - prev_q.t),
    .busy_o  (div_busy),
    .quo_o   (frac)
  );

  always_comb begin
    case (axis_q)
      kli_pkg::AXIS_X: begin
        a = prev_q.x;
        b = nxt_q.x;
      end
      kli_pkg::AXIS_Y: begin
        a = prev_q.y;
        b = nxt_q.y;
      end
      default: begin
        a = prev_q.z;
        b = nxt_q.z;
      end
    endcase
  end

  assign diff = $signed({b[kli_pkg::VAL_W-1], b}) - $signed({a[kli_pkg::VAL_W-1], a});
  // Bits above the fraction are the floor of the product over 2^16.
  assign sum  = {{2{a[kli_pkg::VAL_W-1]}}, a} + prod_q[PROD_W-1:kli_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q <= $signed({1'b0, frac}) * diff;
    end
    if (cmd_i.div_start) begin
      axis_q <= kli_pkg::AXIS_X;
    end else if (cmd_i.acc_step) begin
      axis_q <= kli_pkg::axis_e'(axis_q + 2'd1);
    end
  end

  // Result assembly.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_empty) begin
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_z_q      <= '0;
      res_status_q <= kli_pkg::STATUS_EMPTY;
    end else if (cmd_i.res_key) begin
      res_x_q      <= rd_q.x;
      res_y_q      <= rd_q.y;
      res_z_q      <= rd_q.z;
      res_status_q <= cmd_i.res_status;
    end else if (cmd_i.div_start) begin
      res_status_q <= kli_pkg::STATUS_OK;
    end else if (cmd_i.acc_step) begin
      case (axis_q)
        kli_pkg::AXIS_X: res_x_q <= sum[kli_pkg::VAL_W-1:0];
        kli_pkg::AXIS_Y: res_y_q <= sum[kli_pkg::VAL_W-1:0];
        default:         res_z_q <= sum[kli_pkg::VAL_W-1:0];
      endcase
    end
  end

  // Output register; it holds an item until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_z_q      <= res_z_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.n_zero    = n == '0;
  assign sts_o.n_one     = n == CNT_W'(1);
  assign sts_o.q_lt_cur  = q_q < rd_q.t;
  assign sts_o.q_eq_cur  = q_q == rd_q.t;
  assign sts_o.cur_last  = cur_q == (n - CNT_W'(1));
  assign sts_o.div_busy  = div_busy;
  assign sts_o.axis_last = axis_q == kli_pkg::AXIS_Z;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign out_status_o = out_status_q;

endmodule

### rtl/kli_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences loads, the key scan, the divide, the three multiplies and output.
// ----------------------------------------------------------------------------
module kli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_mode_i,
  output logic          in_ready_o,
  input  kli_pkg::sts_t sts_i,
  output kli_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_FIRST = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_mode_i) begin
            cmd_o.key_wr = 1'b1;
          end else begin
            cmd_o.q_load = 1'b1;
            if (sts_i.n_zero) begin
              cmd_o.res_empty = 1'b1;
              state_d         = S_DONE;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        cmd_o.idx_inc = 1'b1;
        state_d       = S_FIRST;
      end
      S_FIRST: begin
        cmd_o.idx_inc = 1'b1;
        if (sts_i.n_one) begin
          cmd_o.res_key    = 1'b1;
          cmd_o.res_status = kli_pkg::STATUS_OK;
          state_d          = S_DONE;
        end else if (sts_i.q_lt_cur) begin
          cmd_o.res_key    = 1'b1;
          cmd_o.res_status = kli_pkg::STATUS_BEFORE;
          state_d          = S_DONE;
        end else begin
          cmd_o.prev_load = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.q_lt_cur) begin
          cmd_o.nxt_load  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.cur_last) begin
          cmd_o.res_key    = 1'b1;
          cmd_o.res_status = sts_i.q_eq_cur ? kli_pkg::STATUS_OK : kli_pkg::STATUS_AFTER;
          state_d          = S_DONE;
        end else begin
          cmd_o.prev_load = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d        = sts_i.axis_last ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/keyframe_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Samples one track of 3-D keys with linear interpolation in fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  load or query item
//   m_axis    out        m_axis_tvalid / m_axis_tready  x, y, z and status
//   cfg       in         cfg_we_i                       key count register
//
// A load item is written on acceptance; the next item may follow directly.
// A query scans the keys from the start of the track: the scan reads one key per
// cycle from the single read port of the key memory, and the fraction comes
// from a radix-2 divider that yields one bit per cycle, followed by three
// passes through one shared multiplier. An empty track skips the scan, the divide
// and the multiplies and goes straight to the output register.
// Reset clears only control state; the key memory is not cleared and holds
// whatever was written. A stalled output holds its item while loads and the
// next query are still accepted; that query then waits for the output.
//
module keyframe_linear_interpolator_top #(
  parameter int unsigned MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: key count.
  input  logic                            cfg_we_i,
  input  logic [kli_pkg::CNT_IN_W-1:0]    cfg_wdata_i,
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: key_index[6], key_time[32], key_x[32], key_y[32],
  // key_z[32], query_time[32], then two zero bits.
  input  logic [kli_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: mode[1] (0 load, 1 query).
  input  logic                            s_axis_tuser,
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: out_x[32], out_y[32], out_z[32].
  output logic [kli_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: status[2].
  output logic [1:0]                      m_axis_tuser
);

  kli_pkg::cmd_t                cmd;
  kli_pkg::sts_t                sts;
  logic [kli_pkg::VAL_W-1:0]    out_x, out_y, out_z;
  kli_pkg::status_e             out_status;

  // The controller only accepts items in its idle state, so the valid it
  // sees already qualifies the handshake.
  kli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kli_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_index_i  (s_axis_tdata[5:0]),
    .key_time_i   (s_axis_tdata[37:6]),
    .key_x_i      (s_axis_tdata[69:38]),
    .key_y_i      (s_axis_tdata[101:70]),
    .key_z_i      (s_axis_tdata[133:102]),
    .query_time_i (s_axis_tdata[165:134]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_z_o      (out_z),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};
  assign m_axis_tuser = out_status;

endmodule

### rtl/kli_checker.sv
// ----------------------------------------------------------------------------
// Keyframe interpolator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_top_macros.svh"

module kli_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kli_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  // A stalled result keeps its value.
  `KLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A query occupies the block, so no item is taken right after it.
  `KLI_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

  // Loads never stall the input; the block stays ready after a load.
  `KLI_ASSERT_NEXT(a_load_fast, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready)

  // An empty track reports a zero vector.
  `KLI_ASSERT_SAME(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == kli_pkg::STATUS_EMPTY), m_axis_tdata == '0)

endmodule

bind keyframe_linear_interpolator_top kli_checker u_kli_checker (.*);
